// ===== design/mlfb_pkg.sv =====
// Shared types and constants of the memory LCD frame buffer.
package mlfb_pkg;

  localparam int unsigned COLS     = 128;
  localparam int unsigned BORDER   = 16;
  localparam logic [7:0]  OR_MAX_Y = 8'(127 - 16);

  localparam logic [2:0] FUNC_SET_PIXEL    = 3'd0;
  localparam logic [2:0] FUNC_OR_SIXTEEN   = 3'd1;
  localparam logic [2:0] FUNC_FILL_BLACK   = 3'd2;
  localparam logic [2:0] FUNC_FILL_WHITE   = 3'd3;
  localparam logic [2:0] FUNC_BORDERS      = 3'd4;
  localparam logic [2:0] FUNC_START_REFR   = 3'd5;
  localparam logic [2:0] FUNC_TICK         = 3'd6;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_BUSY  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam logic [63:0] BORDER_LO = 64'h0000_0000_0000_ffff;
  localparam logic [63:0] BORDER_HI = 64'hffff_0000_0000_0000;

  typedef enum logic [2:0] {
    OP_ACK,
    OP_RMW,
    OP_FILL,
    OP_LINES,
    OP_DONE
  } op_t;

  typedef enum logic [1:0] {
    FILL_BLACK,
    FILL_WHITE,
    FILL_BORDER
  } fill_t;

  typedef struct packed {
    op_t          op;
    logic [1:0]   status;
    fill_t        fill;
    logic [7:0]   row;
    logic [127:0] mask;
    logic         color;
  } cmd_t;

endpackage

// ===== design/mlfb_in_if.sv =====
// Operation channel of the frame buffer.
interface mlfb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  coord_x;
  logic [7:0]  coord_y;
  logic        color;
  logic [15:0] pattern;

  modport source(output valid, func, coord_x, coord_y, color, pattern, input ready);
  modport sink(input valid, func, coord_x, coord_y, color, pattern, output ready);
endinterface

// ===== design/mlfb_out_if.sv =====
// Result channel of the frame buffer.
interface mlfb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [7:0]  line_number;
  logic [63:0] pixels_low;
  logic [63:0] pixels_high;
  logic        last;

  modport source(output valid, kind, status, line_number, pixels_low, pixels_high, last,
                 input ready);
  modport sink(input valid, kind, status, line_number, pixels_low, pixels_high, last,
               output ready);
endinterface

// ===== design/mlfb_front.sv =====
// Front end: accepts operations, checks ranges, tracks refresh progress, queues commands.
module mlfb_front import mlfb_pkg::*; #(
  parameter int unsigned LINES          = 128,
  parameter int unsigned LINES_PER_TICK = 16
) (
  input  logic      clk,
  input  logic      rst,
  mlfb_in_if.sink   cmd,
  input  logic      q_full,
  input  logic      init_busy,
  output logic      q_push,
  output cmd_t      q_data
);

  localparam int unsigned NLW = $clog2(LINES + 1);
  localparam int unsigned SW  = $clog2(LINES + LINES_PER_TICK + 1);

  logic [NLW-1:0] next_line;
  logic           refresh_done;
  logic [SW-1:0]  sum;
  logic           can_send;
  logic           y_out;
  logic           x_out;

  assign cmd.ready = !q_full && !init_busy;
  assign q_push    = cmd.valid && cmd.ready;

  assign sum      = SW'(next_line) + SW'(LINES_PER_TICK);
  assign can_send = !refresh_done && (sum <= SW'(LINES));
  assign y_out    = {1'b0, cmd.coord_y} >= 9'(LINES);
  assign x_out    = {1'b0, cmd.coord_x} >= 9'(LINES);

  always_comb begin
    q_data        = '0;
    q_data.op     = OP_ACK;
    q_data.status = STAT_OK;
    q_data.fill   = FILL_WHITE;
    unique case (cmd.func)
      FUNC_SET_PIXEL: begin
        if (cmd.coord_x[7] || y_out) begin
          q_data.status = STAT_RANGE;
        end else begin
          q_data.op    = OP_RMW;
          q_data.row   = cmd.coord_y;
          q_data.mask  = 128'(1) << cmd.coord_x[6:0];
          q_data.color = cmd.color;
        end
      end
      FUNC_OR_SIXTEEN: begin
        priority if (!refresh_done) begin
          q_data.status = STAT_BUSY;
        end else if (x_out || (cmd.coord_y > OR_MAX_Y)) begin
          q_data.status = STAT_RANGE;
        end else begin
          q_data.op    = OP_RMW;
          q_data.row   = cmd.coord_x;
          q_data.mask  = 128'(cmd.pattern) << (OR_MAX_Y[6:0] - cmd.coord_y[6:0]);
          q_data.color = 1'b1;
        end
      end
      FUNC_FILL_BLACK: begin
        q_data.op   = OP_FILL;
        q_data.fill = FILL_BLACK;
      end
      FUNC_FILL_WHITE: begin
        q_data.op   = OP_FILL;
        q_data.fill = FILL_WHITE;
      end
      FUNC_BORDERS: begin
        q_data.op   = OP_FILL;
        q_data.fill = FILL_BORDER;
      end
      FUNC_TICK: begin
        if (can_send) begin
          q_data.op  = OP_LINES;
          q_data.row = 8'(next_line);
        end else begin
          q_data.op = OP_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_line    <= '0;
      refresh_done <= 1'b0;
    end else if (q_push) begin
      if (cmd.func == FUNC_START_REFR) begin
        next_line    <= '0;
        refresh_done <= 1'b0;
      end else if (cmd.func == FUNC_TICK) begin
        if (can_send) begin
          next_line <= NLW'(sum);
        end else begin
          refresh_done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/mlfb_queue.sv =====
// Two-entry command queue between front and back end.
module mlfb_queue import mlfb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t pop_data
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== design/mlfb_back.sv =====
// Back end: frame memory, read-modify-write, fill sweeps, line readout and result register.
module mlfb_back import mlfb_pkg::*; #(
  parameter int unsigned LINES          = 128,
  parameter int unsigned LINES_PER_TICK = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cmd_t       q_data,
  output logic       q_pop,
  output logic       init_busy,
  mlfb_out_if.source res
);

  localparam int unsigned DEPTH = LINES * 2;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = AW - 1;
  localparam int unsigned KW    = $clog2(LINES_PER_TICK + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_WR0,
    ST_RD1,
    ST_WR1,
    ST_FILL,
    ST_LRD_LO,
    ST_LRD_HI,
    ST_LEMIT,
    ST_EMIT
  } state_t;

  state_t         state;
  logic           init;
  logic [AW-1:0]  fill_addr;
  fill_t          fill;
  logic [7:0]     cur_row;
  logic [KW-1:0]  k;
  logic [127:0]   mask;
  logic           color;
  logic [1:0]     emit_kind;
  logic [1:0]     emit_status;
  logic [63:0]    lo_word;

  logic [63:0]    mem [DEPTH];
  logic [63:0]    rd_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           we;
  logic [AW-1:0]  wr_addr;
  logic [63:0]    wr_data;

  logic [RW-1:0]  row_a;
  logic [RW-1:0]  fill_row;
  logic           border_row;
  logic [63:0]    fill_word;
  logic           out_free;
  logic           res_load;

  assign init_busy = init;
  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign out_free  = !res.valid || res.ready;
  assign res_load  = out_free && ((state == ST_LEMIT) || (state == ST_EMIT));
  assign row_a     = cur_row[RW-1:0];
  assign fill_row  = fill_addr[AW-1:1];
  assign border_row = (fill_row < RW'(BORDER))
                   || (({2'b00, fill_row} + (RW+2)'(BORDER)) >= (RW+2)'(LINES));

  always_comb begin
    unique case (fill)
      FILL_BLACK:  fill_word = '0;
      FILL_WHITE:  fill_word = '1;
      FILL_BORDER: begin
        if (border_row) begin
          fill_word = '1;
        end else begin
          fill_word = fill_addr[0] ? BORDER_HI : BORDER_LO;
        end
      end
      default:     fill_word = '1;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    we      = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      ST_RD0: begin
        rd_en   = 1'b1;
        rd_addr = {row_a, 1'b0};
      end
      ST_WR0: begin
        we      = 1'b1;
        wr_addr = {row_a, 1'b0};
        wr_data = color ? (rd_data | mask[63:0]) : (rd_data & ~mask[63:0]);
      end
      ST_RD1: begin
        rd_en   = 1'b1;
        rd_addr = {row_a, 1'b1};
      end
      ST_WR1: begin
        we      = 1'b1;
        wr_addr = {row_a, 1'b1};
        wr_data = color ? (rd_data | mask[127:64]) : (rd_data & ~mask[127:64]);
      end
      ST_FILL: begin
        we      = 1'b1;
        wr_addr = fill_addr;
        wr_data = fill_word;
      end
      ST_LRD_LO: begin
        rd_en   = 1'b1;
        rd_addr = {row_a, 1'b0};
      end
      ST_LRD_HI: begin
        rd_en   = 1'b1;
        rd_addr = {row_a, 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      init      <= 1'b1;
      fill      <= FILL_WHITE;
      fill_addr <= '0;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && !res_load) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cur_row     <= q_data.row;
            mask        <= q_data.mask;
            color       <= q_data.color;
            fill        <= q_data.fill;
            emit_kind   <= (q_data.op == OP_DONE) ? KIND_DONE : KIND_ACK;
            emit_status <= q_data.status;
            unique case (q_data.op)
              OP_ACK:   state <= ST_EMIT;
              OP_RMW:   state <= ST_RD0;
              OP_FILL: begin
                fill_addr <= '0;
                state     <= ST_FILL;
              end
              OP_LINES: begin
                k     <= '0;
                state <= ST_LRD_LO;
              end
              OP_DONE:  state <= ST_EMIT;
              default:  state <= ST_EMIT;
            endcase
          end
        end
        ST_RD0: state <= ST_WR0;
        ST_WR0: state <= ST_RD1;
        ST_RD1: state <= ST_WR1;
        ST_WR1: state <= ST_EMIT;
        ST_FILL: begin
          fill_addr <= fill_addr + AW'(1);
          if (fill_addr == AW'(DEPTH - 1)) begin
            init  <= 1'b0;
            state <= init ? ST_IDLE : ST_EMIT;
          end
        end
        ST_LRD_LO: state <= ST_LRD_HI;
        ST_LRD_HI: begin
          lo_word <= rd_data;
          state   <= ST_LEMIT;
        end
        ST_LEMIT: begin
          if (out_free) begin
            res.valid       <= 1'b1;
            res.kind        <= KIND_LINE;
            res.status      <= STAT_OK;
            res.line_number <= cur_row + 8'd1;
            res.pixels_low  <= lo_word;
            res.pixels_high <= rd_data;
            res.last        <= k == KW'(LINES_PER_TICK - 1);
            if (k == KW'(LINES_PER_TICK - 1)) begin
              state <= ST_IDLE;
            end else begin
              k       <= k + KW'(1);
              cur_row <= cur_row + 8'd1;
              state   <= ST_LRD_LO;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            res.valid       <= 1'b1;
            res.kind        <= emit_kind;
            res.status      <= emit_status;
            res.line_number <= '0;
            res.pixels_low  <= '0;
            res.pixels_high <= '0;
            res.last        <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/memory_lcd_frame_buffer.sv =====
// Memory LCD frame buffer: top level joining front end, command queue and back end.
//
// Channels: cmd carries one operation per beat (set pixel, OR-16, fills, start
// refresh, tick); res carries result beats, last marks the final beat of an
// operation. Every operation but a tick gives one acknowledge; a tick gives either
// LINES_PER_TICK line beats (line number plus 128 pixels) or one done beat.
// Work per operation, with the receiver always ready:
//   acknowledge only: the result is emitted directly; pixel and OR-16 writes:
//   read-modify-write of both words of the line, one memory access at a time;
//   fills: one memory word per cycle over the whole frame; tick: both words
//   of each line are read, then its line beat is sent, line after line.
// A two-entry command queue lets cmd keep taking beats while the back end
// works and while a result waits in the output register.
// Reset: the back end sweeps the whole frame to white, with cmd.ready
// low; refresh state returns to "refresh pending from line 1".
// A stalled receiver holds the output register and the back end waits; once
// the queue fills, cmd.ready drops.
module memory_lcd_frame_buffer import mlfb_pkg::*; #(
  parameter int unsigned LINES          = 128,
  parameter int unsigned LINES_PER_TICK = 16
) (
  input  logic       clk,
  input  logic       rst,
  mlfb_in_if.sink    cmd,
  mlfb_out_if.source res
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  logic init_busy;
  cmd_t push_data;
  cmd_t pop_data;

  mlfb_front #(
    .LINES          (LINES),
    .LINES_PER_TICK (LINES_PER_TICK)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .q_full    (q_full),
    .init_busy (init_busy),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  mlfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (pop_data)
  );

  mlfb_back #(
    .LINES          (LINES),
    .LINES_PER_TICK (LINES_PER_TICK)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .res       (res)
  );

endmodule

// ===== test/memory_lcd_frame_buffer_test.sv =====
`timescale 1ns / 1ps
// Testbench of the memory LCD frame buffer: directed and random operations, checked beat by beat.
module memory_lcd_frame_buffer_test import mlfb_pkg::*; ();

  localparam int unsigned LINES          = 128;
  localparam int unsigned LINES_PER_TICK = 16;
  localparam int unsigned RANDOM_ITEMS   = 80;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned SETTLE_CYCLES  = 4 * LINES + 64;
  localparam int unsigned HOLD_AFTER     = 50;
  localparam int unsigned LONG_HOLD      = 500;
  localparam logic [2:0]  FUNC_UNUSED    = 3'd7;

  typedef struct {
    logic [2:0]  func;
    logic [7:0]  coord_x;
    logic [7:0]  coord_y;
    logic        color;
    logic [15:0] pattern;
    bit          drain;
  } lcd_op_t;

  typedef struct {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [7:0]  line_number;
    logic [63:0] pixels_low;
    logic [63:0] pixels_high;
    logic        last;
  } lcd_beat_t;

  logic clk = 1'b0;
  logic rst;

  mlfb_in_if  cmd ();
  mlfb_out_if res ();

  memory_lcd_frame_buffer #(
    .LINES          (LINES),
    .LINES_PER_TICK (LINES_PER_TICK)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  always #4 clk = ~clk;

  logic [63:0]  frame_model [LINES * 2];
  int unsigned  refresh_line;
  bit           refresh_finished;

  lcd_op_t      pending_ops [$];
  lcd_beat_t    expected_beats [$];
  lcd_op_t      offered;
  int unsigned  beats_due;
  int unsigned  beats_seen;
  int unsigned  ops_taken;
  int unsigned  mismatches;
  int unsigned  burst_left;
  int unsigned  gap_left;
  int unsigned  hold_left;
  bit           long_hold_done;
  int unsigned  stall_phase;
  logic [15:0]  stall_pattern;
  int unsigned  cycle_count;

  task automatic push_beat(input logic [1:0] kind, input logic [1:0] status,
                           input logic [7:0] line_number, input logic [63:0] lo,
                           input logic [63:0] hi, input logic last);
    lcd_beat_t b;
    b.kind        = kind;
    b.status      = status;
    b.line_number = line_number;
    b.pixels_low  = lo;
    b.pixels_high = hi;
    b.last        = last;
    expected_beats.push_back(b);
    beats_due++;
  endtask

  task automatic apply_operation(input lcd_op_t op);
    logic [1:0]  st;
    int unsigned col;
    int unsigned row;
    int unsigned start;
    bit          acked;
    st    = STAT_OK;
    acked = 1'b1;
    col   = 32'(op.coord_x);
    row   = 32'(op.coord_y);
    case (op.func)
      FUNC_SET_PIXEL: begin
        if (col >= COLS || row >= LINES) begin
          st = STAT_RANGE;
        end else begin
          frame_model[row * 2 + col / 64][col % 64] = op.color;
        end
      end
      FUNC_OR_SIXTEEN: begin
        if (!refresh_finished) begin
          st = STAT_BUSY;
        end else if (op.coord_x >= LINES || op.coord_y > OR_MAX_Y) begin
          st = STAT_RANGE;
        end else begin
          start = 32'(OR_MAX_Y) - 32'(op.coord_y);
          row   = 32'(op.coord_x);
          for (int i = 0; i < 16; i++) begin
            col = start + 32'(i);
            if (op.pattern[i] && col < COLS) frame_model[row * 2 + col / 64][col % 64] = 1'b1;
          end
        end
      end
      FUNC_FILL_BLACK: begin
        foreach (frame_model[w]) frame_model[w] = '0;
      end
      FUNC_FILL_WHITE: begin
        foreach (frame_model[w]) frame_model[w] = '1;
      end
      FUNC_BORDERS: begin
        for (int r = 0; r < LINES; r++) begin
          if (r < BORDER || r + BORDER >= LINES) begin
            frame_model[r * 2]     = '1;
            frame_model[r * 2 + 1] = '1;
          end else begin
            frame_model[r * 2]     = BORDER_LO;
            frame_model[r * 2 + 1] = BORDER_HI;
          end
        end
      end
      FUNC_START_REFR: begin
        refresh_line     = 0;
        refresh_finished = 1'b0;
      end
      FUNC_TICK: begin
        acked = 1'b0;
        if (!refresh_finished && refresh_line + LINES_PER_TICK <= LINES) begin
          for (int k = 0; k < LINES_PER_TICK; k++) begin
            row = refresh_line + 32'(k);
            push_beat(KIND_LINE, STAT_OK, 8'(row + 1), frame_model[row * 2],
                      frame_model[row * 2 + 1], k == LINES_PER_TICK - 1);
          end
          refresh_line += LINES_PER_TICK;
        end else begin
          refresh_finished = 1'b1;
          push_beat(KIND_DONE, STAT_OK, 8'd0, '0, '0, 1'b1);
        end
      end
      default: ;
    endcase
    if (acked) push_beat(KIND_ACK, st, 8'd0, '0, '0, 1'b1);
  endtask

  task automatic add_op(input logic [2:0] func, input logic [7:0] x, input logic [7:0] y,
                        input logic color, input logic [15:0] pattern, input bit drain);
    lcd_op_t op;
    op.func    = func;
    op.coord_x = x;
    op.coord_y = y;
    op.color   = color;
    op.pattern = pattern;
    op.drain   = drain;
    pending_ops.push_back(op);
  endtask

  function automatic lcd_op_t random_op(input bit allow_fill);
    lcd_op_t     op;
    int unsigned pick;
    op.func    = FUNC_SET_PIXEL;
    op.coord_x = 8'($urandom);
    op.coord_y = 8'($urandom);
    op.color   = 1'($urandom);
    op.pattern = 16'($urandom);
    op.drain   = 1'b0;
    pick       = $urandom_range(0, 99);
    if (pick < 45) begin
      if (pick < 40) begin
        op.coord_x = 8'($urandom_range(0, COLS - 1));
        op.coord_y = 8'($urandom_range(0, LINES - 1));
      end
    end else if (pick < 85) begin
      op.func = FUNC_OR_SIXTEEN;
      if (pick < 80) begin
        op.coord_x = 8'($urandom_range(0, LINES - 1));
        op.coord_y = 8'($urandom_range(0, OR_MAX_Y));
      end
    end else if (pick < 90) begin
      op.func = FUNC_UNUSED;
    end else if (pick < 93) begin
      op.func = FUNC_TICK;
    end else if (allow_fill) begin
      if (pick < 95)      op.func = FUNC_FILL_BLACK;
      else if (pick < 97) op.func = FUNC_FILL_WHITE;
      else                op.func = FUNC_BORDERS;
    end
    return op;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      cmd.valid  <= 1'b0;
      burst_left = $urandom_range(1, 12);
      gap_left   = 0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        apply_operation(offered);
        ops_taken <= ops_taken + 1;
      end
      if (cmd.valid && !cmd.ready) begin
        // hold the beat
      end else if (gap_left > 0) begin
        gap_left--;
        cmd.valid <= 1'b0;
      end else if (pending_ops.size() != 0 && (!pending_ops[0].drain || beats_seen == beats_due))
      begin
        offered = pending_ops.pop_front();
        cmd.valid   <= 1'b1;
        cmd.func    <= offered.func;
        cmd.coord_x <= offered.coord_x;
        cmd.coord_y <= offered.coord_y;
        cmd.color   <= offered.color;
        cmd.pattern <= offered.pattern;
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern and long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res.ready   <= 1'b0;
      hold_left   = 0;
      stall_phase = 0;
    end else begin
      if (!long_hold_done && ops_taken >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        if (stall_phase == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pattern = '1;
            1:       stall_pattern = 16'($urandom);
            2:       stall_pattern = 16'h1111;
            default: stall_pattern = 16'($urandom | $urandom);
          endcase
          stall_phase = 48;
        end
        stall_phase--;
        res.ready <= stall_pattern[stall_phase % 16];
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    lcd_beat_t want;
    if (!rst && res.valid && res.ready) begin
      beats_seen <= beats_seen + 1;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, kind %0d line %0d", $time, res.kind, res.line_number);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        check_field("kind", 64'(want.kind), 64'(res.kind));
        check_field("status", 64'(want.status), 64'(res.status));
        check_field("line_number", 64'(want.line_number), 64'(res.line_number));
        check_field("pixels_low", want.pixels_low, res.pixels_low);
        check_field("pixels_high", want.pixels_high, res.pixels_high);
        check_field("last", 64'(want.last), 64'(res.last));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[memory_lcd_frame_buffer] ERROR");
    $finish;
  end

  initial begin
    int unsigned target;
    int unsigned ticks;
    rst         = 1'b1;
    cmd.valid   = 1'b0;
    cmd.func    = FUNC_SET_PIXEL;
    cmd.coord_x = '0;
    cmd.coord_y = '0;
    cmd.color   = 1'b0;
    cmd.pattern = '0;
    res.ready   = 1'b0;
    foreach (frame_model[w]) frame_model[w] = '1;
    refresh_line     = 0;
    refresh_finished = 1'b0;
    beats_due        = 0;
    beats_seen       = 0;
    ops_taken        = 0;
    mismatches       = 0;
    long_hold_done   = 1'b0;

    // refresh pending after reset: OR-16 is refused
    add_op(FUNC_OR_SIXTEEN, 8'd0, 8'd0, 1'b0, 16'hffff, 1'b0);
    add_op(FUNC_OR_SIXTEEN, 8'd255, 8'd255, 1'b1, 16'h0000, 1'b0);
    add_op(FUNC_SET_PIXEL, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0);
    add_op(FUNC_SET_PIXEL, 8'd127, 8'd127, 1'b0, 16'hffff, 1'b0);
    add_op(FUNC_SET_PIXEL, 8'd128, 8'd5, 1'b1, 16'h0000, 1'b0);
    add_op(FUNC_SET_PIXEL, 8'd5, 8'd128, 1'b0, 16'h0000, 1'b0);
    add_op(FUNC_SET_PIXEL, 8'd255, 8'd255, 1'b1, 16'h0000, 1'b0);
    repeat (LINES / LINES_PER_TICK + 2) add_op(FUNC_TICK, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0);
    add_op(FUNC_OR_SIXTEEN, 8'd3, 8'd0, 1'b0, 16'hffff, 1'b1);
    add_op(FUNC_OR_SIXTEEN, 8'd127, 8'd111, 1'b1, 16'ha5a5, 1'b0);
    add_op(FUNC_OR_SIXTEEN, 8'd128, 8'd0, 1'b0, 16'hffff, 1'b0);
    add_op(FUNC_OR_SIXTEEN, 8'd0, 8'd112, 1'b0, 16'hffff, 1'b0);
    add_op(FUNC_OR_SIXTEEN, 8'd255, 8'd255, 1'b1, 16'hffff, 1'b0);
    add_op(FUNC_BORDERS, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0);
    add_op(FUNC_FILL_BLACK, 8'hff, 8'hff, 1'b1, 16'hffff, 1'b0);
    add_op(FUNC_UNUSED, 8'd17, 8'd33, 1'b1, 16'h1234, 1'b0);
    add_op(FUNC_START_REFR, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0);
    add_op(FUNC_TICK, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0);
    add_op(FUNC_FILL_WHITE, 8'd0, 8'd0, 1'b0, 16'h0000, 1'b0);

    target = pending_ops.size() + RANDOM_ITEMS;
    while (pending_ops.size() < target) begin
      add_op(FUNC_START_REFR, 8'($urandom), 8'($urandom), 1'($urandom), 16'($urandom),
             $urandom_range(0, 5) == 0);
      if ($urandom_range(0, 7) == 0) ticks = $urandom_range(1, LINES / LINES_PER_TICK);
      else ticks = LINES / LINES_PER_TICK + $urandom_range(1, 2);
      repeat (ticks) begin
        add_op(FUNC_TICK, 8'($urandom), 8'($urandom), 1'($urandom), 16'($urandom), 1'b0);
        repeat ($urandom_range(0, 2)) pending_ops.push_back(random_op(1'b0));
      end
      repeat ($urandom_range(4, 12)) pending_ops.push_back(random_op(1'b1));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() != 0 || cmd.valid || expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("[memory_lcd_frame_buffer] OK");
    end else begin
      $display("[memory_lcd_frame_buffer] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mlfb_pkg.sv
design/mlfb_in_if.sv
design/mlfb_out_if.sv
design/mlfb_front.sv
design/mlfb_queue.sv
design/mlfb_back.sv
design/memory_lcd_frame_buffer.sv
test/memory_lcd_frame_buffer_test.sv
